[design/atrlc_pkg.sv]
// ----------------------------------------------------------------------------
// atrlc_pkg
// Shared types and constants of the AT response line classifier.
// ----------------------------------------------------------------------------
package atrlc_pkg;

  localparam int unsigned NumLiterals = 17;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [15:0] LinkMax = 16'hFFFF;

  // result kinds
  localparam logic [3:0] KindOther   = 4'd0;
  localparam logic [3:0] KindConnect = 4'd12;
  localparam logic [3:0] KindClosed  = 4'd13;
  localparam logic [3:0] KindDomain  = 4'd14;
  localparam logic [3:0] KindStation = 4'd15;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t ch;
    logic  end_of_line;
  } item_t;

  // literal text, character at position p
  function automatic byte_t lit_char(input int unsigned idx, input int unsigned p);
    string s;
    byte_t c;
    case (idx)
      0:  s = "OK";
      1:  s = "ERROR";
      2:  s = "FAIL";
      3:  s = "SEND OK";
      4:  s = "SEND FAIL";
      5:  s = "ALREADY CONNECTED";
      6:  s = "WIFI CONNECTED";
      7:  s = "WIFI GOT IP";
      8:  s = "WIFI DISCONNECT";
      9:  s = ">";
      10: s = "busy ";
      11: s = "CONNECT";
      12: s = "CLOSED";
      13: s = "+CIPDOMAIN:";
      14: s = "+CIFSR:STAIP,";
      15: s = "+CIPSTA:ip:";
      default: s = "+CIPSTA:\"";
    endcase
    c = 8'd0;
    if (p < s.len()) c = s[p];
    return c;
  endfunction

  function automatic logic [4:0] lit_len(input int unsigned idx);
    logic [4:0] l;
    case (idx)
      0:  l = 5'd2;
      1:  l = 5'd5;
      2:  l = 5'd4;
      3:  l = 5'd7;
      4:  l = 5'd9;
      5:  l = 5'd17;
      6:  l = 5'd14;
      7:  l = 5'd11;
      8:  l = 5'd15;
      9:  l = 5'd1;
      10: l = 5'd5;
      11: l = 5'd7;
      12: l = 5'd6;
      13: l = 5'd11;
      14: l = 5'd13;
      15: l = 5'd11;
      default: l = 5'd9;
    endcase
    return l;
  endfunction

  function automatic logic lit_prefix(input int unsigned idx);
    return (idx == 10) || (idx >= 13);
  endfunction

  function automatic byte_t verb_connect(input logic [2:0] p);
    byte_t c;
    case (p)
      3'd0: c = "C";
      3'd1: c = "O";
      3'd2: c = "N";
      3'd3: c = "N";
      3'd4: c = "E";
      3'd5: c = "C";
      default: c = "T";
    endcase
    return c;
  endfunction

  function automatic byte_t verb_closed(input logic [2:0] p);
    byte_t c;
    case (p)
      3'd0: c = "C";
      3'd1: c = "L";
      3'd2: c = "O";
      3'd3: c = "S";
      3'd4: c = "E";
      default: c = "D";
    endcase
    return c;
  endfunction

endpackage

[design/atrlc_queue.sv]
// ----------------------------------------------------------------------------
// atrlc_queue
// Small first-in first-out queue of line words between front and back.
// ----------------------------------------------------------------------------
module atrlc_queue #(
  parameter int unsigned Depth = atrlc_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  atrlc_pkg::item_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output atrlc_pkg::item_t rd_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  atrlc_pkg::item_t    mem_r [Depth];
  logic [PtrW-1:0]     wptr_r, rptr_r;
  logic [PtrW:0]       cnt_r;
  logic                push, pop;

  assign wr_ready = (cnt_r != (PtrW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PtrW'(Depth - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PtrW'(Depth - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

[design/atrlc_front.sv]
// ----------------------------------------------------------------------------
// atrlc_front
// Input stage: skips leading spaces and text after a zero byte, and passes
// the remaining bytes and the end-of-line word on to the queue.
// ----------------------------------------------------------------------------
module atrlc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_ch,
  input  logic             in_end_of_line,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             q_valid,
  input  logic             q_ready,
  output atrlc_pkg::item_t q_data
);

  logic lead_r, lead_nxt;
  logic ended_r, ended_nxt;
  logic drop, acc;

  // drop bytes that need no work in the back part
  assign drop = !in_end_of_line &&
                (ended_r || in_ch == 8'd0 || (lead_r && in_ch == 8'h20));
  assign in_ready = drop || q_ready;
  assign q_valid  = in_valid && !drop;
  assign q_data   = '{ch: in_ch, end_of_line: in_end_of_line};
  assign acc      = in_valid && in_ready;

  always_comb begin
    lead_nxt  = lead_r;
    ended_nxt = ended_r;
    if (acc) begin
      if (in_end_of_line) begin
        lead_nxt  = 1'b1;
        ended_nxt = 1'b0;
      end else if (!ended_r) begin
        if (in_ch == 8'd0) begin
          ended_nxt = 1'b1;
        end else if (!(lead_r && in_ch == 8'h20)) begin
          lead_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 1'b1;
      ended_r <= 1'b0;
    end else begin
      lead_r  <= lead_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

[design/atrlc_back.sv]
// ----------------------------------------------------------------------------
// atrlc_back
// Matcher: updates literal, link, verb and address state for each byte and
// registers one classification on each end-of-line word.
// ----------------------------------------------------------------------------
module atrlc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  atrlc_pkg::item_t q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_kind,
  output logic             out_link_present,
  output logic [15:0]      out_link_number,
  output logic [31:0]      out_ip_address
);

  typedef enum logic [2:0] {
    IP_IDLE, IP_LEAD, IP_BARE, IP_QUOTED, IP_QDONE, IP_FAIL
  } ip_t;

  localparam int unsigned NL = atrlc_pkg::NumLiterals;

  logic [4:0]    pos_r, pos_nxt;
  logic [NL-1:0] mask_r, mask_nxt;
  logic [1:0]    cph_r, cph_nxt;
  logic [15:0]   link_r, link_nxt;
  logic [1:0]    vmask_r, vmask_nxt;
  logic [2:0]    vpos_r, vpos_nxt;
  ip_t           ips_r, ips_nxt;
  logic [7:0]    oct_r, oct_nxt;
  logic [1:0]    odig_r, odig_nxt;
  logic [1:0]    ocnt_r, ocnt_nxt;
  logic [23:0]   addr_r, addr_nxt;
  logic [31:0]   qaddr_r, qaddr_nxt;

  logic          ov_r, ok_ld;
  logic [3:0]    kind_r, kind_c;
  logic          pres_r, pres_c;
  logic [15:0]   lnum_r, lnum_c;
  logic [31:0]   ip_r, ip_c;

  logic          take;
  atrlc_pkg::byte_t c;
  logic          is_dig;
  logic [3:0]    dval;
  logic [19:0]   lsum;
  logic [11:0]   osum;
  logic          quad_ok;

  assign q_ready = !ov_r || out_ready || !q_data.end_of_line;
  assign take    = q_valid && q_ready;
  assign ok_ld   = take && q_data.end_of_line;
  assign c       = q_data.ch;
  assign is_dig  = (c >= 8'h30) && (c <= 8'h39);
  assign dval    = c[3:0];
  assign lsum    = {1'b0, link_r, 3'b000} + {3'b000, link_r, 1'b0} + 20'(dval);
  assign osum    = {1'b0, oct_r, 3'b000} + {3'b000, oct_r, 1'b0} + 12'(dval);
  assign quad_ok = (odig_r != 2'd0) && (ocnt_r == 2'd3);

  // byte update
  always_comb begin
    logic [4:0] p1;
    p1        = pos_r;
    pos_nxt   = pos_r;
    mask_nxt  = mask_r;
    cph_nxt   = cph_r;
    link_nxt  = link_r;
    vmask_nxt = vmask_r;
    vpos_nxt  = vpos_r;
    ips_nxt   = ips_r;
    oct_nxt   = oct_r;
    odig_nxt  = odig_r;
    ocnt_nxt  = ocnt_r;
    addr_nxt  = addr_r;
    qaddr_nxt = qaddr_r;

    for (int i = 0; i < NL; i++) begin
      if (pos_r < atrlc_pkg::lit_len(i)) begin
        if (atrlc_pkg::lit_char(i, 32'(pos_r)) != c) mask_nxt[i] = 1'b0;
      end else if (!atrlc_pkg::lit_prefix(i)) begin
        mask_nxt[i] = 1'b0;
      end
    end

    if (!cph_r[1]) begin
      if (c == 8'h2C) begin
        cph_nxt = (cph_r == 2'd0 && pos_r != 5'd0) ? 2'd2 : 2'd3;
      end else if (is_dig) begin
        if (cph_r == 2'd0) link_nxt = (lsum > 20'(atrlc_pkg::LinkMax)) ?
                                      atrlc_pkg::LinkMax : lsum[15:0];
      end else begin
        cph_nxt = 2'd1;
      end
    end else if (cph_r == 2'd2) begin
      if (vpos_r == 3'd7) begin
        vmask_nxt = 2'b00;
      end else begin
        // bit 0 tracks CONNECT, bit 1 tracks CLOSED
        if (atrlc_pkg::verb_connect(vpos_r) != c) vmask_nxt[0] = 1'b0;
        if (vpos_r >= 3'd6 || atrlc_pkg::verb_closed(vpos_r) != c) vmask_nxt[1] = 1'b0;
        vmask_nxt = vmask_nxt & vmask_r;
        vpos_nxt  = vpos_r + 3'd1;
      end
    end

    // address parser
    begin
      logic dotted;
      dotted = 1'b0;
      unique case (ips_r)
        IP_LEAD: begin
          if (c == 8'h22) ips_nxt = IP_QUOTED;
          else if (c != 8'h20) begin
            ips_nxt = IP_BARE;
            dotted  = 1'b1;
          end
        end
        IP_BARE: dotted = 1'b1;
        IP_QUOTED: begin
          if (c == 8'h22) begin
            if (quad_ok) begin
              qaddr_nxt = {addr_r, oct_r};
              ips_nxt   = IP_QDONE;
            end else begin
              ips_nxt = IP_FAIL;
            end
          end else begin
            dotted = 1'b1;
          end
        end
        default: ;
      endcase
      if (dotted) begin
        if (is_dig) begin
          if (odig_r == 2'd3 || osum > 12'd255) ips_nxt = IP_FAIL;
          else begin
            oct_nxt  = osum[7:0];
            odig_nxt = odig_r + 2'd1;
          end
        end else if (c == 8'h2E) begin
          if (odig_r == 2'd0 || ocnt_r == 2'd3) ips_nxt = IP_FAIL;
          else begin
            addr_nxt = {addr_r[15:0], oct_r};
            ocnt_nxt = ocnt_r + 2'd1;
            odig_nxt = 2'd0;
            oct_nxt  = 8'd0;
          end
        end else begin
          ips_nxt = IP_FAIL;
        end
      end
    end

    if (pos_r != 5'd31) p1 = pos_r + 5'd1;
    pos_nxt = p1;

    // start the address parser once an address prefix is complete
    if (ips_r == IP_IDLE) begin
      for (int i = 13; i < NL; i++) begin
        if (mask_nxt[i] && p1 == atrlc_pkg::lit_len(i) && ips_nxt == IP_IDLE) begin
          ips_nxt = (i == NL - 1) ? IP_QUOTED : IP_LEAD;
        end
      end
    end
  end

  // classification
  always_comb begin
    logic done;
    done   = 1'b0;
    kind_c = atrlc_pkg::KindOther;
    pres_c = 1'b0;
    lnum_c = 16'd0;
    ip_c   = 32'd0;
    for (int i = 0; i < 11; i++) begin
      if (!done && mask_r[i] && (atrlc_pkg::lit_prefix(i) ?
          pos_r >= atrlc_pkg::lit_len(i) : pos_r == atrlc_pkg::lit_len(i))) begin
        kind_c = 4'(i + 1);
        done   = 1'b1;
      end
    end
    if (!done && cph_r == 2'd2) begin
      if (vmask_r[0] && vpos_r == 3'd7) begin
        kind_c = atrlc_pkg::KindConnect;
        pres_c = 1'b1;
        lnum_c = link_r;
        done   = 1'b1;
      end else if (vmask_r[1] && vpos_r == 3'd6) begin
        kind_c = atrlc_pkg::KindClosed;
        pres_c = 1'b1;
        lnum_c = link_r;
        done   = 1'b1;
      end
    end
    if (!done && mask_r[11] && pos_r == 5'd7) begin
      kind_c = atrlc_pkg::KindConnect;
      done   = 1'b1;
    end
    if (!done && mask_r[12] && pos_r == 5'd6) begin
      kind_c = atrlc_pkg::KindClosed;
      done   = 1'b1;
    end
    for (int i = 13; i < NL; i++) begin
      if (!done && mask_r[i] && pos_r >= atrlc_pkg::lit_len(i)) begin
        done = 1'b1;
        if (ips_r == IP_BARE && quad_ok) begin
          ip_c   = {addr_r, oct_r};
          kind_c = (i == 13) ? atrlc_pkg::KindDomain : atrlc_pkg::KindStation;
        end else if (ips_r == IP_QDONE) begin
          ip_c   = qaddr_r;
          kind_c = (i == 13) ? atrlc_pkg::KindDomain : atrlc_pkg::KindStation;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ok_ld) begin
      pos_r   <= '0;
      mask_r  <= '1;
      cph_r   <= 2'd0;
      link_r  <= '0;
      vmask_r <= 2'b11;
      vpos_r  <= '0;
      ips_r   <= IP_IDLE;
      oct_r   <= '0;
      odig_r  <= '0;
      ocnt_r  <= '0;
      addr_r  <= '0;
      qaddr_r <= '0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      mask_r  <= mask_nxt;
      cph_r   <= cph_nxt;
      link_r  <= link_nxt;
      vmask_r <= vmask_nxt;
      vpos_r  <= vpos_nxt;
      ips_r   <= ips_nxt;
      oct_r   <= oct_nxt;
      odig_r  <= odig_nxt;
      ocnt_r  <= ocnt_nxt;
      addr_r  <= addr_nxt;
      qaddr_r <= qaddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ok_ld) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ok_ld) begin
      kind_r <= kind_c;
      pres_r <= pres_c;
      lnum_r <= lnum_c;
      ip_r   <= ip_c;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = kind_r;
  assign out_link_present = pres_r;
  assign out_link_number  = lnum_r;
  assign out_ip_address   = ip_r;

endmodule

[design/at_response_line_classifier_unit.sv]
// With the queue empty, out_valid rises once the accepted end-of-line word has
// been written into the queue and then loaded into the result register.
// Throughput: one word per cycle unless a result awaits out_ready.
// Skipped bytes (leading spaces, text after a zero byte) never enter the queue.
// Reset: rst_n low for one cycle clears the queue, matcher state and out_valid.
// ----------------------------------------------------------------------------
// at_response_line_classifier_unit
// Classifies one modem response line per end-of-line word.
// ----------------------------------------------------------------------------
module at_response_line_classifier_unit #(
  parameter int unsigned QueueDepth = atrlc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic        out_link_present,
  output logic [15:0] out_link_number,
  output logic [31:0] out_ip_address
);

  logic             fq_valid, fq_ready, qb_valid, qb_ready;
  atrlc_pkg::item_t fq_data, qb_data;

  atrlc_front u_front (
    .clk, .rst_n, .in_ch, .in_end_of_line, .in_valid, .in_ready,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  atrlc_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  atrlc_back u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid, .out_ready, .out_kind, .out_link_present,
    .out_link_number, .out_ip_address
  );

endmodule
